// ===== sv/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, codes, types and ring index helpers of the double-ended
// queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = IDX_W + 1;
	localparam int WORD_W = 32;

	typedef logic [2:0]              action_t;
	typedef logic [1:0]              status_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic signed [WORD_W-1:0] word_t;

	localparam action_t ACT_PUSH_FRONT = 3'd0;
	localparam action_t ACT_PUSH_BACK  = 3'd1;
	localparam action_t ACT_POP_FRONT  = 3'd2;
	localparam action_t ACT_POP_BACK   = 3'd3;
	localparam action_t ACT_DUMP       = 3'd4;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_EMPTY   = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
	localparam status_t ST_INVALID = 2'd3;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		logic  re;
		idx_t  raddr;
	} mem_req_t;

	typedef struct packed {
		logic valid;
		logic last;
	} rd_tag_t;

	typedef struct packed {
		logic    valid;
		status_t status;
	} dir_res_t;

	function automatic idx_t ring_add(idx_t base, idx_t off);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic idx_t ring_dec(idx_t base);
		idx_t res;
		if (base == '0) begin
			res = IDX_W'(DEPTH - 1);
		end else begin
			res = base - IDX_W'(1);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== sv/dq_in_if.sv =====
// ----------------------------------------------------------------------------
// dq_in_if
// Input channel of the double-ended queue: one action word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dq_in_if;
	import dq_pkg::*;

	logic    valid;
	logic    ready;
	action_t action;
	word_t   value;

	modport source(output valid, output action, output value, input ready);
	modport sink(input valid, input action, input value, output ready);

endinterface

`default_nettype wire

// ===== sv/dq_out_if.sv =====
// ----------------------------------------------------------------------------
// dq_out_if
// Result channel of the double-ended queue: one result word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dq_out_if;
	import dq_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	word_t   data;
	logic    last;

	modport source(output valid, output status, output data, output last, input ready);
	modport sink(input valid, input status, input data, input last, output ready);

endinterface

`default_nettype wire

// ===== sv/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Ring pointer control and dump sequencer. Decodes each accepted word,
// issues the ring store accesses and either a direct result or a read tag.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire dq_pkg::action_t  in_action,
	input  wire dq_pkg::word_t    in_value,
	input  wire logic             out_free,
	input  wire logic             rd_busy,
	input  wire logic             rd_slot_free,
	output logic                  in_ready,
	output dq_pkg::mem_req_t      mem_req,
	output dq_pkg::rd_tag_t       rd_tag,
	output dq_pkg::dir_res_t      dir_res
);
	import dq_pkg::*;

	idx_t front_q, front_d;
	cnt_t count_q, count_d;
	idx_t dump_idx_q, dump_idx_d;
	logic busy_q, busy_d;
	logic accept;
	logic full, empty;
	logic dump_last;

	assign in_ready  = !busy_q && !rd_busy && out_free;
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign dump_last = ((CNT_W'(dump_idx_q) + CNT_W'(1)) == count_q);

	always_comb begin
		front_d    = front_q;
		count_d    = count_q;
		dump_idx_d = dump_idx_q;
		busy_d     = busy_q;
		mem_req    = '0;
		rd_tag     = '0;
		dir_res    = '0;

		if (busy_q) begin
			if (rd_slot_free) begin
				mem_req.re    = 1'b1;
				mem_req.raddr = ring_add(front_q, dump_idx_q);
				rd_tag.valid  = 1'b1;
				rd_tag.last   = dump_last;
				dump_idx_d    = dump_idx_q + IDX_W'(1);
				if (dump_last) begin
					busy_d = 1'b0;
				end
			end
		end else if (accept) begin
			unique case (in_action)
				ACT_PUSH_FRONT: begin
					dir_res.valid = 1'b1;
					if (full) begin
						dir_res.status = ST_FULL;
					end else begin
						dir_res.status = ST_OK;
						front_d        = ring_dec(front_q);
						mem_req.we     = 1'b1;
						mem_req.waddr  = ring_dec(front_q);
						mem_req.wdata  = in_value;
						count_d        = count_q + CNT_W'(1);
					end
				end
				ACT_PUSH_BACK: begin
					dir_res.valid = 1'b1;
					if (full) begin
						dir_res.status = ST_FULL;
					end else begin
						dir_res.status = ST_OK;
						mem_req.we     = 1'b1;
						mem_req.waddr  = ring_add(front_q, count_q[IDX_W-1:0]);
						mem_req.wdata  = in_value;
						count_d        = count_q + CNT_W'(1);
					end
				end
				ACT_POP_FRONT: begin
					if (empty) begin
						dir_res.valid  = 1'b1;
						dir_res.status = ST_EMPTY;
					end else begin
						mem_req.re    = 1'b1;
						mem_req.raddr = front_q;
						rd_tag.valid  = 1'b1;
						rd_tag.last   = 1'b1;
						front_d       = ring_add(front_q, IDX_W'(1));
						count_d       = count_q - CNT_W'(1);
					end
				end
				ACT_POP_BACK: begin
					if (empty) begin
						dir_res.valid  = 1'b1;
						dir_res.status = ST_EMPTY;
					end else begin
						mem_req.re    = 1'b1;
						mem_req.raddr = ring_add(front_q, IDX_W'(count_q - CNT_W'(1)));
						rd_tag.valid  = 1'b1;
						rd_tag.last   = 1'b1;
						count_d       = count_q - CNT_W'(1);
					end
				end
				ACT_DUMP: begin
					if (empty) begin
						dir_res.valid  = 1'b1;
						dir_res.status = ST_EMPTY;
					end else begin
						mem_req.re    = 1'b1;
						mem_req.raddr = front_q;
						rd_tag.valid  = 1'b1;
						rd_tag.last   = (count_q == CNT_W'(1));
						dump_idx_d    = IDX_W'(1);
						busy_d        = (count_q != CNT_W'(1));
					end
				end
				default: begin
					dir_res.valid  = 1'b1;
					dir_res.status = ST_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			count_q    <= '0;
			dump_idx_q <= '0;
			busy_q     <= 1'b0;
		end else begin
			front_q    <= front_d;
			count_q    <= count_d;
			dump_idx_q <= dump_idx_d;
			busy_q     <= busy_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_ring.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_ring
// Bounded double-ended queue of signed 32-bit words held in a ring store.
// ----------------------------------------------------------------------------
// A push, a rejected push, an empty pop or dump and an invalid action each
// give one result straight into the output register. A successful pop reads
// its word from the registered RAM read port, then into that register. A dump
// streams the stored words one word per cycle while the receiver accepts them,
// paced by the single read port of the ring store. Every result sits in an
// output register; a new word is taken only when that register is empty or
// its result is accepted in the same cycle, so a stalled receiver stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_ring (
	input  wire logic clk,
	input  wire logic arst_n,
	dq_in_if.sink     in_ch,
	dq_out_if.source  out_ch
);
	import dq_pkg::*;

	mem_req_t mem_req;
	rd_tag_t  rd_tag;
	dir_res_t dir_res;
	word_t    rdata;
	logic     rd_valid_s1;
	logic     rd_last_s1;
	logic     out_valid_q;
	status_t  out_status_q;
	word_t    out_data_q;
	logic     out_last_q;
	logic     out_free;
	logic     rd_slot_free;
	logic     rd_adv;

	assign out_free     = !out_valid_q || out_ch.ready;
	assign rd_adv       = rd_valid_s1 && out_free;
	assign rd_slot_free = !rd_valid_s1 || out_free;

	dq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_action    (in_ch.action),
		.in_value     (in_ch.value),
		.out_free     (out_free),
		.rd_busy      (rd_valid_s1),
		.rd_slot_free (rd_slot_free),
		.in_ready     (in_ch.ready),
		.mem_req      (mem_req),
		.rd_tag       (rd_tag),
		.dir_res      (dir_res)
	);

	dq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else if (rd_tag.valid) begin
			rd_valid_s1 <= 1'b1;
		end else if (rd_adv) begin
			rd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_tag.valid) begin
			rd_last_s1 <= rd_tag.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_adv || dir_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_adv) begin
			out_status_q <= ST_OK;
			out_data_q   <= rdata;
			out_last_q   <= rd_last_s1;
		end else if (dir_res.valid) begin
			out_status_q <= dir_res.status;
			out_data_q   <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.status = out_status_q;
	assign out_ch.data   = out_data_q;
	assign out_ch.last   = out_last_q;

endmodule

`default_nettype wire

// ===== sv/dq_checker.sv =====
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire dq_pkg::action_t  in_action,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire dq_pkg::status_t  out_status,
	input wire dq_pkg::word_t    out_data,
	input wire logic             out_last
);
	import dq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result word dropped while stalled.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_OK |-> out_data == '0)
		else $error("Failed action carries nonzero data.");

	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_status == ST_OK)
		else $error("Non-final result without ok status.");

	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_action > ACT_DUMP)
		|=> out_valid && out_last && out_status == ST_INVALID)
		else $error("Invalid action not reported in the next cycle.");

endmodule

bind double_ended_queue_ring dq_checker u_dq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_action  (in_ch.action),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_status (out_ch.status),
	.out_data   (out_ch.data),
	.out_last   (out_ch.last)
);

`default_nettype wire
